[rtl/hefk_pkg.sv]
// Package for the head/eye forward kinematics block.
// Holds widths, CORDIC arctangent table, calibration constants and helpers.
// Used by every module in rtl/.
package hefk_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int FRAC_BITS     = 14;
    localparam int CORE_BITS     = 30;
    localparam int CW            = 34;           // CORDIC x/y/z datapath width
    localparam int SW            = FRAC_BITS + 2; // sin/cos width
    localparam int PW            = 2 * SW;        // product width
    localparam int TW            = 6 + 2 * FRAC_BITS + 10; // translation accumulator
    localparam int TABLE_LEN     = 24;
    localparam int NSTG          = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;
    localparam int STW           = $clog2(TABLE_LEN);

    localparam logic signed [CW-1:0] CORE_GAIN = 34'sd652032874;
    localparam logic signed [15:0] LEN_A = 16'sd1395;
    localparam logic signed [15:0] LEN_B = 16'sd2838;
    localparam logic signed [15:0] LEN_C = 16'sd8762;
    localparam logic signed [15:0] LEN_D = 16'sd3424;

    localparam logic signed [SW-1:0] ONE_Q  = SW'(1) <<< FRAC_BITS;

    // ceil(2^56 / (2 * den)) per joint, and the rounding half-step folded into it
    localparam logic [63:0] RCP_NECK  = ((64'd1 << 56) + 64'd359) / 64'd360;
    localparam logic [63:0] RCP_PAN   = ((64'd1 << 56) + 64'd2167) / 64'd2168;
    localparam logic [63:0] RCP_TILT  = ((64'd1 << 56) + 64'd2143) / 64'd2144;
    localparam logic [63:0] BIAS_NECK = (64'd180 * RCP_NECK) >> 33;
    localparam logic [63:0] BIAS_PAN  = (64'd1084 * RCP_PAN) >> 33;
    localparam logic [63:0] BIAS_TILT = (64'd1072 * RCP_TILT) >> 33;

    typedef logic signed [CW-1:0] cw_t;
    typedef logic signed [SW-1:0] sq_t;

    // one CORDIC lane: x, y, residual angle and quadrant
    typedef struct packed {
        cw_t        x;
        cw_t        y;
        cw_t        z;
        logic [1:0] quad;
    } lane_t;

    // three joints travel together through the chain
    typedef struct packed {
        lane_t l2;
        lane_t l3;
        lane_t l4;
    } cell_data_t;

    function automatic cw_t atan_turn(input logic [STW-1:0] i);
        unique case (i)
            5'd0:  atan_turn = 34'sh20000000;
            5'd1:  atan_turn = 34'sh12E4051D;
            5'd2:  atan_turn = 34'sh09FB385B;
            5'd3:  atan_turn = 34'sh051111D4;
            5'd4:  atan_turn = 34'sh028B0D43;
            5'd5:  atan_turn = 34'sh0145D7E1;
            5'd6:  atan_turn = 34'sh00A2F61E;
            5'd7:  atan_turn = 34'sh00517C55;
            5'd8:  atan_turn = 34'sh0028BE53;
            5'd9:  atan_turn = 34'sh00145F2E;
            5'd10: atan_turn = 34'sh000A2F98;
            5'd11: atan_turn = 34'sh000517CC;
            5'd12: atan_turn = 34'sh00028BE6;
            5'd13: atan_turn = 34'sh000145F3;
            5'd14: atan_turn = 34'sh0000A2F9;
            5'd15: atan_turn = 34'sh0000517C;
            5'd16: atan_turn = 34'sh000028BE;
            5'd17: atan_turn = 34'sh0000145F;
            5'd18: atan_turn = 34'sh00000A2F;
            5'd19: atan_turn = 34'sh00000517;
            5'd20: atan_turn = 34'sh0000028B;
            5'd21: atan_turn = 34'sh00000145;
            5'd22: atan_turn = 34'sh000000A2;
            5'd23: atan_turn = 34'sh00000051;
            default: atan_turn = '0;
        endcase
    endfunction

    // reading to turn fraction: round(d * 2^32 / den), ties up, modulo one turn.
    // The offset reading d is kept positive by adding whole periods; the quotient
    // (d * 2^33 + den) / (2 * den) is a multiply by the reciprocal, exact below 2^44.
    function automatic logic [31:0] turn_of(input logic [10:0] d,
                                            input logic [63:0] rcp,
                                            input logic [63:0] bias);
        logic [63:0] acc;
        acc = 64'(d) * rcp + bias;
        turn_of = acc[54:23];
    endfunction

    function automatic logic [31:0] th2_of(input logic [9:0] r);
        th2_of = turn_of(11'(r) + 11'd123, RCP_NECK, BIAS_NECK);
    endfunction
    function automatic logic [31:0] th3_of(input logic [9:0] r);
        th3_of = turn_of(11'(r) + 11'd775, RCP_PAN, BIAS_PAN) - 32'h40000000;
    endfunction
    function automatic logic [31:0] th4_of(input logic [9:0] r);
        th4_of = turn_of(11'(r) + 11'd761, RCP_TILT, BIAS_TILT);
    endfunction

    // round-shift right by s (ties up), then clamp to +-one
    function automatic sq_t sat_one(input logic signed [63:0] v, input int s);
        logic signed [63:0] r;
        r = (s > 0) ? ((v + (64'sd1 <<< (s - 1))) >>> s) : v;
        if (r > 64'(ONE_Q)) r = 64'(ONE_Q);
        else if (r < -64'(ONE_Q)) r = -64'(ONE_Q);
        sat_one = r[SW-1:0];
    endfunction

    function automatic logic signed [15:0] rot_out(input sq_t v);
        logic signed [63:0] r;
        if (FRAC_BITS >= 14) r = 64'(sat_one(64'(v), FRAC_BITS - 14));
        else r = 64'(v) <<< (14 - FRAC_BITS);
        if (r > 64'sd16384) r = 64'sd16384;
        else if (r < -64'sd16384) r = -64'sd16384;
        rot_out = r[15:0];
    endfunction

    function automatic logic signed [14:0] trans_out(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] r;
        r = (v + (TW'(1) <<< (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
        if (r > TW'(16383)) r = TW'(16383);
        else if (r < -TW'(16384)) r = -TW'(16384);
        trans_out = r[14:0];
    endfunction

endpackage

[rtl/hefk_cell.sv]
// One CORDIC micro-rotation cell for the three joint lanes.
// Depends on hefk_pkg.
module hefk_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic [hefk_pkg::STW-1:0] idx,
    input  logic                    vld_in,
    input  hefk_pkg::cell_data_t    d_in,
    output logic                    vld_out,
    output hefk_pkg::cell_data_t    d_out
);
    import hefk_pkg::*;

    logic       vld_reg;
    cell_data_t d_reg;
    cell_data_t d_next;
    cw_t        a;

    function automatic lane_t rot(input lane_t l, input cw_t ang, input logic [STW-1:0] s);
        lane_t o;
        o = l;
        if (!l.z[CW-1]) begin
            o.x = l.x - (l.y >>> s);
            o.y = l.y + (l.x >>> s);
            o.z = l.z - ang;
        end else begin
            o.x = l.x + (l.y >>> s);
            o.y = l.y - (l.x >>> s);
            o.z = l.z + ang;
        end
        rot = o;
    endfunction

    always_comb
    begin
        a         = atan_turn(idx);
        d_next.l2 = rot(d_in.l2, a, idx);
        d_next.l3 = rot(d_in.l3, a, idx);
        d_next.l4 = rot(d_in.l4, a, idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= 1'b0;
        else if (en) vld_reg <= vld_in;
    end

    always_ff @(posedge clk)
    begin
        if (en) d_reg <= d_next;
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;
endmodule

[rtl/hefk_post.sv]
// Output stages: quadrant fold, angle-sum products, matrix entries, translations.
// Depends on hefk_pkg.
module hefk_post (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vld_in,
    input  hefk_pkg::cell_data_t d_in,
    output logic                 vld_out,
    output logic signed [15:0]   rot_00,
    output logic signed [15:0]   rot_01,
    output logic signed [15:0]   rot_02,
    output logic signed [14:0]   trans_x,
    output logic signed [15:0]   rot_10,
    output logic signed [15:0]   rot_11,
    output logic signed [15:0]   rot_12,
    output logic signed [14:0]   trans_y,
    output logic signed [15:0]   rot_21,
    output logic signed [15:0]   rot_22,
    output logic signed [14:0]   trans_z
);
    import hefk_pkg::*;

    logic [3:0] vld_reg;
    sq_t s2, c2, s3, c3, s4, c4;
    sq_t s2_reg, c2_reg, s3_reg, c3_reg, s4_reg, c4_reg;
    sq_t s2b_reg, c2b_reg, s4b_reg, c4b_reg;
    logic signed [PW-1:0] p23a_reg, p23b_reg, p23c_reg, p23d_reg;
    sq_t s23_reg, c23_reg, s4c_reg, c4c_reg, s2c_reg, c2c_reg;
    logic signed [15:0] r00_reg, r01_reg, r02_reg, r10_reg, r11_reg, r12_reg;
    logic signed [15:0] r21_reg, r22_reg;
    logic signed [14:0] tx_reg, ty_reg, tz_reg;
    sq_t s23, c23;

    function automatic void fold(input lane_t l, output sq_t s, output sq_t c);
        cw_t cx, sy;
        unique case (l.quad)
            2'd0: begin cx = l.x;  sy = l.y;  end
            2'd1: begin cx = -l.y; sy = l.x;  end
            2'd2: begin cx = -l.x; sy = -l.y; end
            default: begin cx = l.y; sy = -l.x; end
        endcase
        c = sat_one(64'(cx), CORE_BITS - FRAC_BITS);
        s = sat_one(64'(sy), CORE_BITS - FRAC_BITS);
    endfunction

    function automatic sq_t mulq(input sq_t a, input sq_t b);
        mulq = sat_one(64'(a) * 64'(b), FRAC_BITS);
    endfunction

    function automatic logic signed [TW-1:0] lmul(input logic signed [15:0] l,
                                                  input sq_t a, input sq_t b);
        lmul = TW'(l) * TW'(a) * TW'(b);
    endfunction

    always_comb
    begin
        fold(d_in.l2, s2, c2);
        fold(d_in.l3, s3, c3);
        fold(d_in.l4, s4, c4);
    end

    always_comb
    begin
        s23 = sat_one(64'(p23a_reg) + 64'(p23b_reg), FRAC_BITS);
        c23 = sat_one(64'(p23c_reg) - 64'(p23d_reg), FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[2:0], vld_in};
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            // stage 1: fold quadrants and round
            s2_reg <= s2; c2_reg <= c2;
            s3_reg <= s3; c3_reg <= c3;
            s4_reg <= s4; c4_reg <= c4;
            // stage 2: angle-sum products
            p23a_reg <= s2_reg * c3_reg;
            p23b_reg <= s3_reg * c2_reg;
            p23c_reg <= c2_reg * c3_reg;
            p23d_reg <= s2_reg * s3_reg;
            s2b_reg <= s2_reg; c2b_reg <= c2_reg;
            s4b_reg <= s4_reg; c4b_reg <= c4_reg;
            // stage 3: round the pan sums
            s23_reg <= s23; c23_reg <= c23;
            s4c_reg <= s4b_reg; c4c_reg <= c4b_reg;
            s2c_reg <= s2b_reg; c2c_reg <= c2b_reg;
            // stage 4: entries
            r00_reg <= rot_out(-s23_reg);
            r01_reg <= rot_out(-mulq(c23_reg, s4c_reg));
            r02_reg <= rot_out(-mulq(c23_reg, c4c_reg));
            r10_reg <= rot_out(c23_reg);
            r11_reg <= rot_out(-mulq(s23_reg, s4c_reg));
            r12_reg <= rot_out(-mulq(s23_reg, c4c_reg));
            r21_reg <= rot_out(-c4c_reg);
            r22_reg <= rot_out(s4c_reg);
            tx_reg <= trans_out(-lmul(LEN_A, c23_reg, c4c_reg)
                                - lmul(LEN_B, s23_reg, ONE_Q)
                                - lmul(LEN_C, c2c_reg, ONE_Q));
            ty_reg <= trans_out(-lmul(LEN_A, s23_reg, c4c_reg)
                                + lmul(LEN_B, c23_reg, ONE_Q)
                                - lmul(LEN_C, s2c_reg, ONE_Q));
            tz_reg <= trans_out(lmul(LEN_A, s4c_reg, ONE_Q) + lmul(LEN_D, ONE_Q, ONE_Q));
        end
    end

    assign vld_out = vld_reg[3];
    assign rot_00 = r00_reg;
    assign rot_01 = r01_reg;
    assign rot_02 = r02_reg;
    assign rot_10 = r10_reg;
    assign rot_11 = r11_reg;
    assign rot_12 = r12_reg;
    assign rot_21 = r21_reg;
    assign rot_22 = r22_reg;
    assign trans_x = tx_reg;
    assign trans_y = ty_reg;
    assign trans_z = tz_reg;
endmodule

[rtl/head_eye_forward_kinematics.sv]
// Head/eye forward kinematics: world-from-left-eye transform entries.
// Channels: in_valid/in_stall carry three 10-bit joint readings;
// out_valid/out_stall carry eleven transform entries (Q1.14 rotation,
// 1/64 mm translation). A request is taken when valid is high and stall low.
// Pipeline: the angle-map register, one register per CORDIC stage (16 cells),
// and the post-processing stages of hefk_post, from input to output request.
// Throughput: one request per cycle while the output is not stalled; the whole pipeline holds up to 21 in flight.
// The whole pipeline advances together; when the receiver stalls with a
// result waiting, the chain holds and in_stall rises, so nothing is lost.
// Reset clears every valid flag; the data registers are not reset.
// Depends on hefk_pkg, hefk_cell and hefk_post.
module head_eye_forward_kinematics (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [9:0]         neck_pan_reading,
    input  logic [9:0]         eye_pan_reading,
    input  logic [9:0]         eye_tilt_reading,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] rot_00,
    output logic signed [15:0] rot_01,
    output logic signed [15:0] rot_02,
    output logic signed [14:0] trans_x,
    output logic signed [15:0] rot_10,
    output logic signed [15:0] rot_11,
    output logic signed [15:0] rot_12,
    output logic signed [14:0] trans_y,
    output logic signed [15:0] rot_21,
    output logic signed [15:0] rot_22,
    output logic signed [14:0] trans_z
);
    import hefk_pkg::*;

    logic       en;
    logic       v0_reg;
    cell_data_t d0_reg;
    cell_data_t d0_next;
    logic       vc [0:NSTG];
    cell_data_t dc [0:NSTG];

    function automatic lane_t start(input logic [31:0] a);
        lane_t l;
        l.x    = CORE_GAIN;
        l.y    = '0;
        l.z    = CW'(a[29:0]);
        l.quad = a[31:30];
        start  = l;
    endfunction

    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    always_comb
    begin
        d0_next.l2 = start(th2_of(neck_pan_reading));
        d0_next.l3 = start(th3_of(eye_pan_reading));
        d0_next.l4 = start(th4_of(eye_tilt_reading));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v0_reg <= 1'b0;
        else if (en) v0_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en) d0_reg <= d0_next;
    end

    assign vc[0] = v0_reg;
    assign dc[0] = d0_reg;

    for (genvar g = 0; g < NSTG; g++) begin : g_cell
        hefk_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .idx     (STW'(g)),
            .vld_in  (vc[g]),
            .d_in    (dc[g]),
            .vld_out (vc[g+1]),
            .d_out   (dc[g+1])
        );
    end

    hefk_post u_post (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vc[NSTG]),
        .d_in    (dc[NSTG]),
        .vld_out (out_valid),
        .rot_00  (rot_00),
        .rot_01  (rot_01),
        .rot_02  (rot_02),
        .trans_x (trans_x),
        .rot_10  (rot_10),
        .rot_11  (rot_11),
        .rot_12  (rot_12),
        .trans_y (trans_y),
        .rot_21  (rot_21),
        .rot_22  (rot_22),
        .trans_z (trans_z)
    );

    // the chain holds exactly while a waiting result is stalled
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while output stalled");
    a_keep: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(rot_00) && $stable(trans_z))
        else $error("stalled result changed");
    a_rot22: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rot_22 <= 16'sd16384 && rot_22 >= -16'sd16384))
        else $error("rot_22 out of range");
endmodule

[tb/sv/head_eye_forward_kinematics_test.sv]
// Testbench for head_eye_forward_kinematics: drives joint readings, predicts the
// world-from-left-eye transform entries and compares every result in order.
// Depends on hefk_pkg for widths and on the RTL top level.
`timescale 1ns / 1ps

class kinematics_scoreboard;
    typedef struct {
        logic signed [15:0] r00, r01, r02, r10, r11, r12, r21, r22;
        logic signed [14:0] tx, ty, tz;
    } pose_t;

    pose_t pending[$];
    int    errors;

    static function longint shr_round(longint v, int s);
        if (s <= 0)
            return v;
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    static function longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    static function logic [31:0] angle_of(longint d, longint den);
        longint n;
        longint q;
        n = d * (64'sd1 <<< 33) + den;
        if (n >= 0)
            q = n / (2 * den);
        else
            q = -((-n + 2 * den - 1) / (2 * den));
        return q[31:0];
    endfunction

    static function longint atan_step(int i);
        longint steps[24] = '{
            'h20000000, 'h12E4051D, 'h09FB385B, 'h051111D4, 'h028B0D43, 'h0145D7E1,
            'h00A2F61E, 'h00517C55, 'h0028BE53, 'h00145F2E, 'h000A2F98, 'h000517CC,
            'h00028BE6, 'h000145F3, 'h0000A2F9, 'h0000517C, 'h000028BE, 'h0000145F,
            'h00000A2F, 'h00000517, 'h0000028B, 'h00000145, 'h000000A2, 'h00000051};
        return steps[i];
    endfunction

    static function void rotate(logic [31:0] a, output longint s, output longint c);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint cx;
        longint sy;
        longint one;
        one = 64'sd1 <<< hefk_pkg::FRAC_BITS;
        x = 652032874;
        y = 0;
        z = longint'(a[29:0]);
        for (int i = 0; i < hefk_pkg::NSTG; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x -= dx; y += dy; z -= atan_step(i);
            end
            else
            begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        case (a[31:30])
            2'd0: begin cx = x;  sy = y;  end
            2'd1: begin cx = -y; sy = x;  end
            2'd2: begin cx = -x; sy = -y; end
            default: begin cx = y; sy = -x; end
        endcase
        c = clip(shr_round(cx, 30 - hefk_pkg::FRAC_BITS), -one, one);
        s = clip(shr_round(sy, 30 - hefk_pkg::FRAC_BITS), -one, one);
    endfunction

    static function logic signed [15:0] to_q14(longint v);
        longint r;
        if (hefk_pkg::FRAC_BITS >= 14)
            r = shr_round(v, hefk_pkg::FRAC_BITS - 14);
        else
            r = v * (64'sd1 <<< (14 - hefk_pkg::FRAC_BITS));
        r = clip(r, -16384, 16384);
        return r[15:0];
    endfunction

    static function logic signed [14:0] to_mm(longint v);
        longint r;
        r = clip(shr_round(v, 2 * hefk_pkg::FRAC_BITS), -16384, 16383);
        return r[14:0];
    endfunction

    static function longint qmul(longint a, longint b);
        longint one;
        one = 64'sd1 <<< hefk_pkg::FRAC_BITS;
        return clip(shr_round(a * b, hefk_pkg::FRAC_BITS), -one, one);
    endfunction

    function void note_request(logic [9:0] neck, logic [9:0] pan, logic [9:0] tilt);
        longint one;
        longint s2, c2, s3, c3, s4, c4, s23, c23;
        pose_t p;
        one = 64'sd1 <<< hefk_pkg::FRAC_BITS;
        rotate(angle_of(longint'(neck) - 237, 180), s2, c2);
        rotate(angle_of(longint'(pan) - 309, 1084) - 32'h40000000, s3, c3);
        rotate(angle_of(longint'(tilt) - 311, 1072), s4, c4);
        s23 = clip(shr_round(s2 * c3 + s3 * c2, hefk_pkg::FRAC_BITS), -one, one);
        c23 = clip(shr_round(c2 * c3 - s2 * s3, hefk_pkg::FRAC_BITS), -one, one);
        p.r00 = to_q14(-s23);
        p.r01 = to_q14(-qmul(c23, s4));
        p.r02 = to_q14(-qmul(c23, c4));
        p.r10 = to_q14(c23);
        p.r11 = to_q14(-qmul(s23, s4));
        p.r12 = to_q14(-qmul(s23, c4));
        p.r21 = to_q14(-c4);
        p.r22 = to_q14(s4);
        p.tx = to_mm(-1395 * c23 * c4 - 2838 * s23 * one - 8762 * c2 * one);
        p.ty = to_mm(-1395 * s23 * c4 + 2838 * c23 * one - 8762 * s2 * one);
        p.tz = to_mm(1395 * s4 * one + 3424 * one * one);
        pending = {pending, p};
    endfunction

    function void field(string name, longint want, longint got);
        if (want != got)
        begin
            errors++;
            $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
        end
    endfunction

    function void check_result(pose_t got);
        pose_t want;
        if (pending.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, expected none actual r00=%0d", $realtime, got.r00);
            return;
        end
        want = pending.pop_front();
        field("rot_00", want.r00, got.r00);
        field("rot_01", want.r01, got.r01);
        field("rot_02", want.r02, got.r02);
        field("trans_x", want.tx, got.tx);
        field("rot_10", want.r10, got.r10);
        field("rot_11", want.r11, got.r11);
        field("rot_12", want.r12, got.r12);
        field("trans_y", want.ty, got.ty);
        field("rot_21", want.r21, got.r21);
        field("rot_22", want.r22, got.r22);
        field("trans_z", want.tz, got.tz);
    endfunction
endclass

module head_eye_forward_kinematics_test;
    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic [9:0] neck_pan_reading;
    logic [9:0] eye_pan_reading;
    logic [9:0] eye_tilt_reading;
    logic out_valid;
    logic out_stall;
    logic signed [15:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_21, rot_22;
    logic signed [14:0] trans_x, trans_y, trans_z;
    logic stim_done;
    int   stall_left;

    kinematics_scoreboard board;

    head_eye_forward_kinematics i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .neck_pan_reading(neck_pan_reading), .eye_pan_reading(eye_pan_reading),
        .eye_tilt_reading(eye_tilt_reading),
        .out_valid(out_valid), .out_stall(out_stall),
        .rot_00(rot_00), .rot_01(rot_01), .rot_02(rot_02), .trans_x(trans_x),
        .rot_10(rot_10), .rot_11(rot_11), .rot_12(rot_12), .trans_y(trans_y),
        .rot_21(rot_21), .rot_22(rot_22), .trans_z(trans_z)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("head_eye_forward_kinematics_test failed");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(logic [9:0] neck, logic [9:0] pan, logic [9:0] tilt);
        int gap;
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        neck_pan_reading <= neck;
        eye_pan_reading <= pan;
        eye_tilt_reading <= tilt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_request(neck, pan, tilt);
    endtask

    // take results and drive the receiver's stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                board.check_result('{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12,
                                     rot_21, rot_22, trans_x, trans_y, trans_z});
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < 25)
                out_stall <= 1'b1;
            else if ($urandom_range(0, 99) < 3)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(10, 40);
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        logic [9:0] edge_vals[6];
        int wait_cycles;
        edge_vals = '{10'd0, 10'd1023, 10'd237, 10'd309, 10'd311, 10'd512};
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        neck_pan_reading = '0;
        eye_pan_reading = '0;
        eye_tilt_reading = '0;
        stim_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration points, range ends and quarter turns of each joint
        for (int i = 0; i < 6; i++)
            send_request(edge_vals[i], edge_vals[(i + 1) % 6], edge_vals[(i + 2) % 6]);
        send_request(10'd282, 10'd580, 10'd579);
        send_request(10'd327, 10'd851, 10'd43);
        send_request(10'd192, 10'd38, 10'd847);
        send_request(10'd1023, 10'd1023, 10'd1023);
        send_request(10'd0, 10'd0, 10'd0);
        send_request(10'h2AA, 10'h155, 10'h2AA);

        for (int n = 0; n < 850; n++)
        begin
            if (n == 400)
            begin
                // hold off until the pipeline has drained
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (board.pending.size() != 0);
            end
            send_request(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         10'($urandom_range(0, 1023)));
        end
        in_valid <= 1'b0;

        wait_cycles = 0;
        while (board.pending.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (30) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("head_eye_forward_kinematics_test passed");
        else
            $display("head_eye_forward_kinematics_test failed");
        $finish;
    end
endmodule

[sim.f]
rtl/hefk_pkg.sv
rtl/hefk_cell.sv
rtl/hefk_post.sv
rtl/head_eye_forward_kinematics.sv
tb/sv/head_eye_forward_kinematics_test.sv
